>>> design/dri_pkg.sv
// Shared types and constants for the dead-reckoning pose integrator.
package dri_pkg;

    // Default sine table size, as log2 of the number of entries per turn.
    localparam int TABLE_BITS_DEF = 12;

    // Heading register width: two turns in units of 2^-16 turn.
    localparam int HEAD_BITS = 17;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Odd polynomial coefficients of the quarter-wave sine, Q30.
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598669;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172272;

    // One odometry tick.
    typedef struct packed {
        logic signed [15:0] linear_velocity;
        logic signed [19:0] angular_rate;
        logic        [15:0] time_step;
    } in_item_t;

    // Pose and yaw quaternion after one tick.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [16:0] heading_angle;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } out_item_t;

    // Operand pair for the shared multiplier.
    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_op_t;

endpackage

>>> design/dead_reckoning_pose_integrator_core.sv
// Top level of the dead-reckoning pose integrator: sequencer, state and datapath.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid / in_ready  | in_item  (velocity, rate, step)
//  out     | output    | out_valid / out_ready| out_item (pose, yaw quaternion)
//
// Between one input transfer and the next, a tick passes through the idle state,
// four sine evaluations of six multiplications each and five pose
// multiplications, every multiplication taking an issue and a write-back step
// on the single shared 33 x 33 multiplier, and a final step to load the result.
// After reset the pose is zero and in_ready is high at once.
// The result sits in an output register; a stalled output holds the next tick
// in its final cycle until the register is free.
module dead_reckoning_pose_integrator_core
    import dri_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int QUART_BITS = TABLE_BITS - 2;
    localparam int SHIFT_X    = 30 - QUART_BITS;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_TRIG_MUL = 6'b000010,
        ST_TRIG_WB  = 6'b000100,
        ST_POSE_MUL = 6'b001000,
        ST_POSE_WB  = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    // Sequencer state.
    state_t      state_reg, state_next;
    logic [2:0]  k_reg, k_next;
    logic [1:0]  trig_reg, trig_next;
    logic        out_valid_reg, out_valid_next;

    // Pose state.
    logic signed [31:0]    x_reg, x_next;
    logic signed [31:0]    y_reg, y_next;
    logic [HEAD_BITS-1:0]  heading_reg, heading_next;

    // Working registers.
    logic signed [15:0] vel_reg, vel_next;
    logic signed [19:0] rate_reg, rate_next;
    logic [15:0]        dt_reg, dt_next;
    logic [30:0]        x2_reg, x2_next;
    logic [30:0]        t_reg, t_next;
    logic signed [31:0] tmp_reg, tmp_next;
    logic signed [15:0] trig_val_reg [4];
    logic signed [15:0] trig_val_next [4];
    out_item_t          out_item_reg, out_item_next;

    // Shared multiplier.
    mul_op_t                  mop;
    logic signed [PROD_W-1:0] prod;

    dri_mul u_mul (
        .clk  (clk),
        .op   (mop),
        .prod (prod)
    );

    // Table index of the current sine evaluation and the quarter-wave argument.
    logic [TABLE_BITS-1:0] half_idx;
    logic [TABLE_BITS-1:0] base_idx;
    logic [1:0]            quad;
    logic [QUART_BITS-1:0] rem;
    logic [QUART_BITS:0]   rr;
    logic [30:0]           arg_x;

    assign half_idx = heading_reg[HEAD_BITS-1 -: TABLE_BITS];
    assign base_idx = trig_reg[1] ? half_idx : {half_idx[TABLE_BITS-2:0], 1'b0};
    assign quad     = base_idx[TABLE_BITS-1 -: 2] + {1'b0, trig_reg[0]};
    assign rem      = base_idx[QUART_BITS-1:0];
    assign rr       = quad[0] ? ({1'b1, {QUART_BITS{1'b0}}} - {1'b0, rem}) : {1'b0, rem};
    assign arg_x    = {rr, {SHIFT_X{1'b0}}};

    // Product views for the write-back steps.
    logic [31:0]        q30;
    logic [16:0]        s_rnd;
    logic signed [15:0] s_mag;
    logic signed [15:0] s_val;
    logic signed [24:0] d_pos;
    logic [16:0]        d_head;
    logic signed [31:0] pos_old;
    logic signed [32:0] pos_sum;
    logic signed [31:0] pos_sat;

    assign q30    = prod[61:30];
    assign s_rnd  = 17'((q30 + 32'h0000_4000) >> 15);
    assign s_mag  = (s_rnd > 17'd32767) ? 16'sd32767 : 16'(s_rnd);
    assign s_val  = quad[1] ? -s_mag : s_mag;
    assign d_pos  = prod[47:23];
    assign d_head = prod[32:16];

    // Saturating position update for x or y.
    assign pos_old = (k_reg == 3'd1) ? x_reg : y_reg;
    assign pos_sum = {pos_old[31], pos_old} + {{8{d_pos[24]}}, d_pos};
    assign pos_sat = (pos_sum[32] != pos_sum[31])
                   ? (pos_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                   : pos_sum[31:0];

    // Multiplier operand selection.
    always_comb
    begin
        mop.a = '0;
        mop.b = '0;
        if (state_reg == ST_TRIG_MUL)
        begin
            case (k_reg)
                3'd0:
                begin
                    mop.a = {2'b00, arg_x};
                    mop.b = {2'b00, arg_x};
                end
                3'd1:
                begin
                    mop.a = {2'b00, x2_reg};
                    mop.b = {2'b00, SIN_C9};
                end
                3'd5:
                begin
                    mop.a = {2'b00, arg_x};
                    mop.b = {2'b00, t_reg};
                end
                default:
                begin
                    mop.a = {2'b00, x2_reg};
                    mop.b = {2'b00, t_reg};
                end
            endcase
        end
        else if (state_reg == ST_POSE_MUL)
        begin
            // The x step takes the cosine, the y step the sine.
            case (k_reg)
                3'd0:
                begin
                    mop.a = MUL_W'(vel_reg);
                    mop.b = MUL_W'(trig_val_reg[1]);
                end
                3'd2:
                begin
                    mop.a = MUL_W'(vel_reg);
                    mop.b = MUL_W'(trig_val_reg[0]);
                end
                3'd4:
                begin
                    mop.a = MUL_W'(rate_reg);
                    mop.b = {{(MUL_W-16){1'b0}}, dt_reg};
                end
                default:
                begin
                    mop.a = MUL_W'(tmp_reg);
                    mop.b = {{(MUL_W-16){1'b0}}, dt_reg};
                end
            endcase
        end
    end

    // Sequencer and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        trig_next      = trig_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        heading_next   = heading_reg;
        vel_next       = vel_reg;
        rate_next      = rate_reg;
        dt_next        = dt_reg;
        x2_next        = x2_reg;
        t_next         = t_reg;
        tmp_next       = tmp_reg;
        trig_val_next  = trig_val_reg;
        out_item_next  = out_item_reg;

        // The output register empties on a transfer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    vel_next   = in_item.linear_velocity;
                    rate_next  = in_item.angular_rate;
                    dt_next    = in_item.time_step;
                    k_next     = 3'd0;
                    trig_next  = 2'd0;
                    state_next = ST_TRIG_MUL;
                end
            end
            ST_TRIG_MUL:
            begin
                state_next = ST_TRIG_WB;
            end
            ST_TRIG_WB:
            begin
                // Horner steps of the quarter-wave polynomial.
                case (k_reg)
                    3'd0: x2_next = q30[30:0];
                    3'd1: t_next  = 31'(SIN_C7 - q30[30:0]);
                    3'd2: t_next  = 31'(SIN_C5 - q30[30:0]);
                    3'd3: t_next  = 31'(SIN_C3 - q30[30:0]);
                    3'd4: t_next  = 31'(SIN_C1 - q30[30:0]);
                    default: trig_val_next[trig_reg] = s_val;
                endcase
                if (k_reg == 3'd5)
                begin
                    k_next = 3'd0;
                    if (trig_reg == 2'd1)
                    begin
                        state_next = ST_POSE_MUL;
                    end
                    else if (trig_reg == 2'd3)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        trig_next  = trig_reg + 2'd1;
                        state_next = ST_TRIG_MUL;
                    end
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_TRIG_MUL;
                end
            end
            ST_POSE_MUL:
            begin
                state_next = ST_POSE_WB;
            end
            ST_POSE_WB:
            begin
                // Velocity times trig, then times the time step, then the heading.
                case (k_reg) inside
                    3'd0, 3'd2: tmp_next = prod[31:0];
                    3'd1: x_next = pos_sat;
                    3'd3: y_next = pos_sat;
                    default: heading_next = heading_reg + d_head;
                endcase
                if (k_reg == 3'd4)
                begin
                    k_next     = 3'd0;
                    trig_next  = 2'd2;
                    state_next = ST_TRIG_MUL;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_POSE_MUL;
                end
            end
            ST_FINISH:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_item_next.pos_x         = x_reg;
                    out_item_next.pos_y         = y_reg;
                    out_item_next.heading_angle = heading_reg;
                    out_item_next.quat_z        = trig_val_reg[2];
                    out_item_next.quat_w        = trig_val_reg[3];
                    out_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and pose registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            trig_reg      <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            trig_reg      <= trig_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            heading_reg   <= heading_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        vel_reg      <= vel_next;
        rate_reg     <= rate_next;
        dt_reg       <= dt_next;
        x2_reg       <= x2_next;
        t_reg        <= t_next;
        tmp_reg      <= tmp_next;
        trig_val_reg <= trig_val_next;
        out_item_reg <= out_item_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A transfer starts the first sine evaluation at its first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_TRIG_MUL && k_reg == 3'd0
                                    && trig_reg == 2'd0))
        else $error("tick did not start at the first sine step");

    // The step counter stays within the longest sub-sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= 3'd5)
        else $error("step counter out of range");

    // The heading holds while a sine of it is being evaluated.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRIG_WB) |=> $stable(heading_reg))
        else $error("heading changed during a sine evaluation");

    // Clamped quaternion terms never reach the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.quat_z != 16'sh8000 && out_item.quat_w != 16'sh8000))
        else $error("quaternion term out of range");

    // A new result is loaded only when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !out_ready) |=> (state_reg == ST_FINISH))
        else $error("result loaded over a pending result");

endmodule

>>> design/dri_mul.sv
// Shared signed multiplier with a registered product.
module dri_mul
    import dri_pkg::*;
(
    input  logic                     clk,
    input  mul_op_t                  op,
    output logic signed [PROD_W-1:0] prod
);

    // One multiplication per cycle; the product is held in a register.
    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op.a * op.b;
    end

    assign prod = prod_reg;

endmodule
